@@ hw/rtl/mp2r_pkg.sv @@
// Shared types and constants for the masked pixel to RGBA8 converter.
// No dependencies; imported by every module of the block.
package mp2r_pkg;

  localparam int unsigned MaskW  = 32;
  localparam int unsigned PosW   = $clog2(MaskW);
  localparam int unsigned QuoW   = 8;
  localparam int unsigned NumW   = MaskW + QuoW;
  localparam int unsigned CfgIdxW = 3;

  // Pipeline depth of one channel: three extract stages, one stage per quotient bit
  localparam int unsigned ChanLatency = 3 + QuoW;
  // Plus the output register in the top level
  localparam int unsigned Latency = ChanLatency + 1;

  localparam logic [QuoW-1:0]  RgbaFull  = 8'd255;
  localparam logic [MaskW-1:0] Low24Mask = 32'h00FF_FFFF;

  localparam logic [MaskW-1:0] RedReset   = 32'h00FF_0000;
  localparam logic [MaskW-1:0] GreenReset = 32'h0000_FF00;
  localparam logic [MaskW-1:0] BlueReset  = 32'h0000_00FF;
  localparam logic [MaskW-1:0] AlphaReset = 32'h0000_0000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THREE_BYTE  = 3'd0,
    CFG_RED_MASK    = 3'd1,
    CFG_GREEN_MASK  = 3'd2,
    CFG_BLUE_MASK   = 3'd3,
    CFG_ALPHA_MASK  = 3'd4
  } cfg_idx_e;

  // One beat of the restoring divider chain
  typedef struct packed {
    logic             zero_mask;
    logic [MaskW-1:0] max;
    logic [NumW-1:0]  rem;
    logic [QuoW-1:0]  quo;
  } div_stage_t;

endpackage

@@ hw/rtl/mp2r_field_extract.sv @@
// Three-stage field extraction: lowest mask bit, shift down, rounded numerator.
// Depends on mp2r_pkg.
module mp2r_field_extract (
  input  logic                        clk_i,
  input  logic [mp2r_pkg::MaskW-1:0]  word_i,
  input  logic [mp2r_pkg::MaskW-1:0]  mask_i,
  output mp2r_pkg::div_stage_t        stage_o
);
  import mp2r_pkg::*;

  logic [MaskW-1:0] low_bit;
  logic [PosW-1:0]  pos_d, pos_q;
  logic [MaskW-1:0] masked_q, mask_q;
  logic [MaskW-1:0] field_d, field_q, max_d, max_q;
  logic             zero_d, zero_q;
  logic [NumW-1:0]  num_d;
  div_stage_t       stage_d, stage_q;

  // Stage 1: isolate the lowest set mask bit and encode its position
  always_comb begin
    low_bit = mask_i & (~mask_i + MaskW'(1));
    pos_d   = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (low_bit[i]) begin
        pos_d = pos_d | PosW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    masked_q <= word_i & mask_i;
    mask_q   <= mask_i;
    pos_q    <= pos_d;
  end

  // Stage 2: shift field and mask down to bit zero
  assign field_d = masked_q >> pos_q;
  assign max_d   = mask_q >> pos_q;
  assign zero_d  = (mask_q == '0);

  always_ff @(posedge clk_i) begin
    field_q <= field_d;
    max_q   <= max_d;
    zero_q  <= zero_d;
  end

  // Stage 3: field*255 + max/2
  assign num_d = (NumW'(field_q) << QuoW) - NumW'(field_q) + NumW'(max_q >> 1);

  always_comb begin
    stage_d.zero_mask = zero_q;
    stage_d.max       = max_q;
    stage_d.rem       = num_d;
    stage_d.quo       = '0;
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o = stage_q;

endmodule

@@ hw/rtl/mp2r_div_step.sv @@
// One registered step of the restoring divider: resolves one quotient bit.
// Depends on mp2r_pkg.
module mp2r_div_step #(
  parameter int unsigned Bit = 0
) (
  input  logic                  clk_i,
  input  mp2r_pkg::div_stage_t  stage_i,
  output mp2r_pkg::div_stage_t  stage_o
);
  import mp2r_pkg::*;

  logic [NumW-1:0] divisor;
  logic [NumW:0]   diff;
  logic            fits;
  div_stage_t      stage_d, stage_q;

  // Trial subtract of max scaled to this quotient bit
  always_comb begin
    divisor = NumW'(stage_i.max) << Bit;
    diff    = {1'b0, stage_i.rem} - {1'b0, divisor};
    fits    = ~diff[NumW];
    stage_d = stage_i;
    if (fits) begin
      stage_d.rem      = diff[NumW-1:0];
      stage_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o = stage_q;

endmodule

@@ hw/rtl/mp2r_channel.sv @@
// One color channel: field extraction followed by an eight-step divider chain.
// Depends on mp2r_pkg, mp2r_field_extract and mp2r_div_step.
module mp2r_channel (
  input  logic                        clk_i,
  input  logic [mp2r_pkg::MaskW-1:0]  word_i,
  input  logic [mp2r_pkg::MaskW-1:0]  mask_i,
  output logic [mp2r_pkg::QuoW-1:0]   quo_o,
  output logic                        zero_mask_o
);
  import mp2r_pkg::*;

  div_stage_t stg [QuoW+1];

  mp2r_field_extract u_extract (
    .clk_i   (clk_i),
    .word_i  (word_i),
    .mask_i  (mask_i),
    .stage_o (stg[0])
  );

  // Quotient bits resolved MSB first, one per stage
  for (genvar g = 0; g < QuoW; g++) begin : g_div
    mp2r_div_step #(
      .Bit (QuoW - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .stage_i (stg[g]),
      .stage_o (stg[g+1])
    );
  end

  assign quo_o       = stg[QuoW].quo;
  assign zero_mask_o = stg[QuoW].zero_mask;

endmodule

@@ hw/rtl/masked_pixel_to_rgba8_converter.sv @@
// Top level of the masked pixel to RGBA8 converter: config registers,
// valid pipeline, four channel lanes and the output register. Uses mp2r_pkg.
//
// A pixel is taken on every cycle that start is high; busy stays low, so a
// pixel may enter each cycle and the block sustains one pixel per clock.
// The result appears on out_valid_o after its start beat passes three
// extraction stages, eight divider stages (one quotient bit each) and
// the output register. Results are shown for one cycle only and
// the receiver cannot stall them. Mask and mode registers are written
// through the cfg port and should only change while no pixel is in flight.
module masked_pixel_to_rgba8_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command side
  input  logic                          start,
  output logic                          busy,
  input  logic [mp2r_pkg::MaskW-1:0]    pixel_word_i,
  // Result side
  output logic                          out_valid_o,
  output logic [mp2r_pkg::QuoW-1:0]     red_out_o,
  output logic [mp2r_pkg::QuoW-1:0]     green_out_o,
  output logic [mp2r_pkg::QuoW-1:0]     blue_out_o,
  output logic [mp2r_pkg::QuoW-1:0]     alpha_out_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [mp2r_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mp2r_pkg::MaskW-1:0]    cfg_data_i
);
  import mp2r_pkg::*;

  logic             three_byte_q;
  logic [MaskW-1:0] red_mask_q, green_mask_q, blue_mask_q, alpha_mask_q;
  logic [MaskW-1:0] word;
  logic [Latency-1:0] valid_q;
  logic [QuoW-1:0]  quo_r, quo_g, quo_b, quo_a;
  logic             zero_r, zero_g, zero_b, zero_a;
  logic [QuoW-1:0]  red_q, green_q, blue_q, alpha_q;

  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_byte_q <= 1'b0;
      red_mask_q   <= RedReset;
      green_mask_q <= GreenReset;
      blue_mask_q  <= BlueReset;
      alpha_mask_q <= AlphaReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THREE_BYTE: three_byte_q <= cfg_data_i[0];
        CFG_RED_MASK:   red_mask_q   <= cfg_data_i;
        CFG_GREEN_MASK: green_mask_q <= cfg_data_i;
        CFG_BLUE_MASK:  blue_mask_q  <= cfg_data_i;
        CFG_ALPHA_MASK: alpha_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // 24-bit mode drops the top byte
  assign word = three_byte_q ? (pixel_word_i & Low24Mask) : pixel_word_i;

  // Valid bits travel beside the lane data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-2:0], start & ~busy};
    end
  end

  mp2r_channel u_red (
    .clk_i(clk_i), .word_i(word), .mask_i(red_mask_q),
    .quo_o(quo_r), .zero_mask_o(zero_r)
  );

  mp2r_channel u_green (
    .clk_i(clk_i), .word_i(word), .mask_i(green_mask_q),
    .quo_o(quo_g), .zero_mask_o(zero_g)
  );

  mp2r_channel u_blue (
    .clk_i(clk_i), .word_i(word), .mask_i(blue_mask_q),
    .quo_o(quo_b), .zero_mask_o(zero_b)
  );

  mp2r_channel u_alpha (
    .clk_i(clk_i), .word_i(word), .mask_i(alpha_mask_q),
    .quo_o(quo_a), .zero_mask_o(zero_a)
  );

  // Output register: empty color mask gives 0, empty alpha mask gives opaque
  always_ff @(posedge clk_i) begin
    red_q   <= zero_r ? '0 : quo_r;
    green_q <= zero_g ? '0 : quo_g;
    blue_q  <= zero_b ? '0 : quo_b;
    alpha_q <= zero_a ? RgbaFull : quo_a;
  end

  assign out_valid_o = valid_q[Latency-1];
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q;

endmodule
